/* rtl/sdtq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types, codes and time arithmetic of the sorted deadline timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

    localparam int unsigned SDTQ_DEPTH = 16;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [31:0] SEC_MAX = 32'hFFFF_FFFF;
    localparam logic [19:0] USEC_MAX = 20'd999999;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_CHECK  = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_FIRED  = 3'd0,
        KIND_ALARM  = 3'd1,
        KIND_CANCEL = 3'd2,
        KIND_HEAD   = 3'd3,
        KIND_FULL   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [31:0] sec;
        logic [19:0] usec;
    } t_time;

    typedef struct packed {
        logic        valid;
        logic [31:0] sec;
        logic [19:0] usec;
        logic [15:0] tag;
    } t_entry;

    // Control from the sequencer to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop;
    } t_chain_op;

    // Status of the chain seen by the sequencer.
    typedef struct packed {
        t_entry head;
        logic   head_le;
        logic   full;
    } t_chain_stat;

    // True when time a is not later than time b.
    function automatic logic not_later(t_time a, t_time b);
        return (a.sec < b.sec) || ((a.sec == b.sec) && (a.usec <= b.usec));
    endfunction

    // Carries a microsecond field of one second or more into the seconds.
    // A 20-bit field stays below two seconds, so one carry is enough.
    function automatic t_time norm_time(logic [31:0] sec, logic [19:0] usec);
        t_time       r;
        logic [32:0] s;
        if (usec >= USEC_PER_SEC) begin
            s = {1'b0, sec} + 33'd1;
            r.usec = usec - USEC_PER_SEC;
        end else begin
            s = {1'b0, sec};
            r.usec = usec;
        end
        r.sec = s[31:0];
        if (s[32]) begin
            r.sec = SEC_MAX;
            r.usec = USEC_MAX;
        end
        return r;
    endfunction

    // Sum of two normalized times, saturated at the largest time.
    function automatic t_time add_time(t_time a, t_time b);
        t_time       r;
        logic [20:0] u;
        logic        c;
        logic [32:0] s;
        u = {1'b0, a.usec} + {1'b0, b.usec};
        c = (u >= {1'b0, USEC_PER_SEC});
        s = {1'b0, a.sec} + {1'b0, b.sec} + {32'd0, c};
        r.sec = s[31:0];
        r.usec = c ? 20'(u - {1'b0, USEC_PER_SEC}) : u[19:0];
        if (s[32]) begin
            r.sec = SEC_MAX;
            r.usec = USEC_MAX;
        end
        return r;
    endfunction

    // Time from b until a, zero when a is not later than b.
    function automatic t_time interval(t_time a, t_time b);
        t_time       r;
        logic [20:0] u;
        if (not_later(a, b)) begin
            r = '0;
        end else if (b.usec > a.usec) begin
            u = {1'b0, a.usec} + {1'b0, USEC_PER_SEC} - {1'b0, b.usec};
            r.sec = a.sec - b.sec - 32'd1;
            r.usec = u[19:0];
        end else begin
            r.sec = a.sec - b.sec;
            r.usec = a.usec - b.usec;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/sdtq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert and
// left on pop.
// ----------------------------------------------------------------------------
module sdtq_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  sdtq_pkg::t_chain_op  i_op,
    input  sdtq_pkg::t_entry     i_new,
    input  sdtq_pkg::t_entry     i_left,
    input  wire                  i_left_le,
    input  sdtq_pkg::t_entry     i_right,
    output sdtq_pkg::t_entry     o_entry,
    output logic                 o_le
);
    import sdtq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_le;

    // The entry stays in front of the new one if its deadline is not later.
    assign w_le = r_entry.valid &&
                  not_later(t_time'{r_entry.sec, r_entry.usec},
                            t_time'{i_new.sec, i_new.usec});

    always_comb begin
        n_entry = r_entry;
        if (i_op.insert && !w_le) begin
            n_entry = i_left_le ? i_new : i_left;
        end else if (i_op.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_le = w_le;

endmodule
`default_nettype wire

/* rtl/sdtq_chain.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_chain
// Row of cells kept in ascending deadline order, head in cell zero.
// ----------------------------------------------------------------------------
module sdtq_chain (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  sdtq_pkg::t_chain_op   i_op,
    input  sdtq_pkg::t_entry      i_new,
    output sdtq_pkg::t_chain_stat o_stat
);
    import sdtq_pkg::*;

    t_entry w_ent [SDTQ_DEPTH];
    logic   w_le  [SDTQ_DEPTH];

    for (genvar g = 0; g < SDTQ_DEPTH; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_le;

        if (g == 0) begin : g_first
            assign w_left = '0;
            assign w_left_le = 1'b1;
        end else begin : g_mid
            assign w_left = w_ent[g-1];
            assign w_left_le = w_le[g-1];
        end

        if (g == SDTQ_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_ent[g+1];
        end

        sdtq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_op      (i_op),
            .i_new     (i_new),
            .i_left    (w_left),
            .i_left_le (w_left_le),
            .i_right   (w_right),
            .o_entry   (w_ent[g]),
            .o_le      (w_le[g])
        );
    end

    assign o_stat.head = w_ent[0];
    assign o_stat.head_le = w_le[0];
    assign o_stat.full = w_ent[SDTQ_DEPTH-1].valid;

endmodule
`default_nettype wire

/* rtl/sorted_deadline_timer_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// A query passes through NORM and QUERY, an insert through NORM, SUM and INS,
// where an immediate fire or full result is written, and then through ALARM
// when it makes a new head. A check passes through NORM and CHECK, which gives
// one fired tag per cycle while the output does not stall, then through ALARM
// for a closing alarm. One request is in work at a time: the next one is taken
// only back in IDLE. Reset clears every valid bit of the chain at once.
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// Timer queue that keeps pending timeouts sorted by deadline in a chain of
// cells and reports fired tags, alarm intervals and the head deadline.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Request stream.
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [119:0] i_s_tdata,  // now_sec, now_usec, delay_sec, delay_usec, tag
    input  wire  [1:0]   i_s_tuser,  // cmd
    // Result stream.
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [71:0]  o_m_tdata,  // fired_tag, time_sec, time_usec, zero fill
    output logic [2:0]   o_m_tuser,  // kind
    output logic         o_m_tlast
);
    import sdtq_pkg::*;

    // Sequencer steps. Every decoded request passes through NORM, where the
    // current time and the delay are normalized; an insert then forms its
    // deadline in SUM and is placed into the chain in INS.
    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_SUM,
        S_INS,
        S_CHECK,
        S_ALARM,
        S_QUERY
    } t_state;

    t_state      r_state;
    t_cmd        r_cmd;
    t_time       r_now;
    t_time       r_dly;
    t_time       r_dl;
    logic [15:0] r_tag;

    logic        r_out_valid;
    logic [2:0]  r_out_kind;
    logic [15:0] r_out_tag;
    t_time       r_out_time;
    logic        r_out_last;

    t_chain_op   w_op;
    t_chain_stat w_stat;
    t_entry      w_new;
    t_time       w_head;
    logic        w_slot;
    logic        w_accept;
    logic        w_new_due;
    logic        w_head_due;
    logic        w_emit;

    assign w_accept = i_s_tvalid && o_s_tready;
    // The output register can take a new result when empty or being drained.
    assign w_slot = !r_out_valid || i_m_tready;

    assign w_head = t_time'{w_stat.head.sec, w_stat.head.usec};
    assign w_new = '{valid: 1'b1, sec: r_dl.sec, usec: r_dl.usec, tag: r_tag};
    // A deadline that is not later than now fires at once and is never stored.
    assign w_new_due = not_later(r_dl, r_now);
    assign w_head_due = w_stat.head.valid && not_later(w_head, r_now);

    // Insert happens in the single INS cycle, pop only when the fired tag
    // is actually written to the output register.
    assign w_op.insert = (r_state == S_INS) && !w_new_due && !w_stat.full;
    assign w_op.pop = (r_state == S_CHECK) && w_head_due && w_slot;

    // High in the cycles where the sequencer writes a result to the output
    // register; a drained result is then replaced instead of cleared.
    always_comb begin
        case (r_state)
            S_INS:   w_emit = w_slot && (w_new_due || w_stat.full);
            S_CHECK: w_emit = w_slot && (w_head_due || !w_stat.head.valid);
            S_ALARM: w_emit = w_slot;
            S_QUERY: w_emit = w_slot;
            default: w_emit = 1'b0;
        endcase
    end

    sdtq_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_new   (w_new),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_m_tready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd <= t_cmd'(i_s_tuser);
                        r_now <= t_time'{i_s_tdata[31:0], i_s_tdata[51:32]};
                        r_dly <= t_time'{i_s_tdata[83:52], i_s_tdata[103:84]};
                        r_tag <= i_s_tdata[119:104];
                        // The unused command code is dropped without a result.
                        if (i_s_tuser != CMD_INSERT && i_s_tuser != CMD_CHECK &&
                            i_s_tuser != CMD_QUERY) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    r_now <= norm_time(r_now.sec, r_now.usec);
                    r_dly <= norm_time(r_dly.sec, r_dly.usec);
                    case (r_cmd)
                        CMD_INSERT: r_state <= S_SUM;
                        CMD_CHECK:  r_state <= S_CHECK;
                        default:    r_state <= S_QUERY;
                    endcase
                end
                S_SUM: begin
                    r_dl <= add_time(r_now, r_dly);
                    r_state <= S_INS;
                end
                S_INS: begin
                    if (w_new_due || w_stat.full) begin
                        if (w_slot) begin
                            r_out_valid <= 1'b1;
                            r_out_kind <= w_new_due ? KIND_FIRED : KIND_FULL;
                            r_out_tag <= w_new_due ? r_tag : 16'd0;
                            r_out_time <= '0;
                            r_out_last <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        // The chain takes the entry in this cycle; only a new
                        // head moves the alarm.
                        r_state <= w_stat.head_le ? S_IDLE : S_ALARM;
                    end
                end
                S_CHECK: begin
                    if (w_head_due) begin
                        if (w_slot) begin
                            r_out_valid <= 1'b1;
                            r_out_kind <= KIND_FIRED;
                            r_out_tag <= w_stat.head.tag;
                            r_out_time <= '0;
                            r_out_last <= 1'b0;
                        end
                    end else if (w_stat.head.valid) begin
                        r_state <= S_ALARM;
                    end else if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_out_kind <= KIND_CANCEL;
                        r_out_tag <= 16'd0;
                        r_out_time <= '0;
                        r_out_last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_ALARM: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_out_kind <= KIND_ALARM;
                        r_out_tag <= 16'd0;
                        r_out_time <= interval(w_head, r_now);
                        r_out_last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_QUERY: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_out_kind <= KIND_HEAD;
                        r_out_tag <= 16'd0;
                        r_out_time <= w_stat.head.valid ? w_head : '0;
                        r_out_last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = {4'd0, r_out_time.usec, r_out_time.sec, r_out_tag};
    assign o_m_tuser = r_out_kind;
    assign o_m_tlast = r_out_last;

`ifndef NO_ASSERTIONS
    // A full chain always has a valid head.
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.full |-> w_stat.head.valid)
        else $error("chain full without a valid head");

    // Only a fired tag from a check can be followed by more results.
    a_nonfired_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != KIND_FIRED) |-> o_m_tlast)
        else $error("non-fired result without last");

    // After an insert the chain holds at least one entry.
    a_insert_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.insert |=> w_stat.head.valid)
        else $error("insert left the chain empty");

    // Insert and pop never happen together.
    a_op_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_op.insert && w_op.pop))
        else $error("insert and pop in the same cycle");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb_sorted_deadline_timer_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_deadline_timer_queue
// Self-checking bench for the sorted deadline timer queue. A directed opening
// covers the empty queue, carries, saturation, equal deadlines and a full
// queue. A long random phase of timer traffic follows. Both streams are
// throttled at random, then run at full rate. Every result is checked
// against a behavioral timer list kept in this file.
// ----------------------------------------------------------------------------
module tb_sorted_deadline_timer_queue;
    import sdtq_pkg::*;

    // Command code that the block does not decode; it must stay silent.
    localparam logic [1:0]  CMD_UNUSED      = 2'd3;
    localparam int unsigned RANDOM_REQUESTS = 420;
    // Cycles without any accepted transfer before the run is declared hung.
    localparam int unsigned STALL_LIMIT     = 4000;
    // Quiet cycles after the last result, enough to cover the insert latency.
    localparam int unsigned SETTLE_CYCLES   = 20;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam logic [63:0] USEC_PER_SEC64  = 64'd1000000;

    // One request as it travels on the request stream.
    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] now_sec;
        logic [19:0] now_usec;
        logic [31:0] delay_sec;
        logic [19:0] delay_usec;
        logic [15:0] tag;
        logic        drain_first;  // hold the request back until all results are in
    } t_request;

    typedef struct {
        t_kind       kind;
        logic [15:0] tag;
        logic [31:0] sec;
        logic [19:0] usec;
        logic        last;
    } t_result;

    typedef struct {
        t_time       deadline;
        logic [15:0] tag;
    } t_timer;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [119:0] i_s_tdata  = '0;
    logic [1:0]   i_s_tuser  = '0;
    logic         i_m_tready = 1'b0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [71:0]  o_m_tdata;
    logic [2:0]   o_m_tuser;
    logic         o_m_tlast;

    t_request     pending_requests[$];
    t_request     next_request;
    t_result      expected_results[$];
    t_result      oldest_result;
    t_timer       timer_list[$];

    int unsigned  total_requests = 0;
    int unsigned  sent_count     = 0;
    int unsigned  tx_idle_pct;
    int unsigned  rx_idle_pct;
    int unsigned  mismatch_count = 0;
    int unsigned  stall_cycles   = 0;
    logic         request_taken  = 1'b0;

    sorted_deadline_timer_queue u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // now_sec, now_usec, delay_sec, delay_usec, tag
        .i_s_tuser  (i_s_tuser),   // cmd
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // fired_tag, time_sec, time_usec, zero fill
        .o_m_tuser  (o_m_tuser),   // kind
        .o_m_tlast  (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Time arithmetic of the timer list. Times are handled as wide integers
    // here so that the bench does not mirror the carry logic of the design.
    // ------------------------------------------------------------------------

    // Folds whole seconds out of the microsecond part and saturates at the
    // largest representable time.
    function automatic t_time carry_time(logic [63:0] sec, logic [63:0] usec);
        t_time r;
        while (usec >= USEC_PER_SEC64) begin
            usec = usec - USEC_PER_SEC64;
            sec  = sec + 64'd1;
        end
        if (sec > 64'hFFFF_FFFF) begin
            r.sec  = SEC_MAX;
            r.usec = USEC_MAX;
        end else begin
            r.sec  = sec[31:0];
            r.usec = usec[19:0];
        end
        return r;
    endfunction

    // True when time a is at or before time b.
    function automatic logic due_by(t_time a, t_time b);
        return {a.sec, a.usec} <= {b.sec, b.usec};
    endfunction

    // Time left from 'from' until 'target', clamped at zero.
    function automatic t_time time_until(t_time target, t_time from);
        logic [63:0] span;
        t_time       r;
        if (due_by(target, from))
            return '0;
        span = ({32'd0, target.sec} * USEC_PER_SEC64 + {44'd0, target.usec})
             - ({32'd0, from.sec} * USEC_PER_SEC64 + {44'd0, from.usec});
        r.sec  = 32'(span / USEC_PER_SEC64);
        r.usec = 20'(span % USEC_PER_SEC64);
        return r;
    endfunction

    function automatic t_result make_result(t_kind kind, logic [15:0] tag, t_time t);
        t_result r;
        r.kind = kind;
        r.tag  = tag;
        r.sec  = t.sec;
        r.usec = t.usec;
        r.last = 1'b0;
        return r;
    endfunction

    // Applies one accepted request to the timer list and queues the results
    // that the block must produce for it, with the last one flagged.
    task automatic predict_timer_results(input logic [1:0] cmd, input logic [119:0] data);
        t_time   now_t;
        t_time   delay_t;
        t_time   deadline;
        t_timer  entry;
        t_result batch[$];
        int      pos;
        now_t   = carry_time({32'd0, data[31:0]}, {44'd0, data[51:32]});
        delay_t = carry_time({32'd0, data[83:52]}, {44'd0, data[103:84]});
        case (cmd)
            CMD_INSERT: begin
                deadline = carry_time({32'd0, now_t.sec} + {32'd0, delay_t.sec},
                                      {44'd0, now_t.usec} + {44'd0, delay_t.usec});
                if (due_by(deadline, now_t)) begin
                    // Already due: the tag fires at once, even on a full queue.
                    batch.push_back(make_result(KIND_FIRED, data[119:104], '0));
                end else if (timer_list.size() >= SDTQ_DEPTH) begin
                    batch.push_back(make_result(KIND_FULL, 16'd0, '0));
                end else begin
                    // New entry goes behind every entry due no later than it.
                    pos = 0;
                    while (pos < timer_list.size() && due_by(timer_list[pos].deadline, deadline))
                        pos++;
                    entry.deadline = deadline;
                    entry.tag      = data[119:104];
                    timer_list.insert(pos, entry);
                    if (pos == 0)
                        batch.push_back(make_result(KIND_ALARM, 16'd0,
                                                    time_until(deadline, now_t)));
                end
            end
            CMD_CHECK: begin
                while (timer_list.size() > 0 && due_by(timer_list[0].deadline, now_t)) begin
                    batch.push_back(make_result(KIND_FIRED, timer_list[0].tag, '0));
                    void'(timer_list.pop_front());
                end
                if (timer_list.size() > 0)
                    batch.push_back(make_result(KIND_ALARM, 16'd0,
                                                time_until(timer_list[0].deadline, now_t)));
                else
                    batch.push_back(make_result(KIND_CANCEL, 16'd0, '0));
            end
            CMD_QUERY: begin
                if (timer_list.size() > 0)
                    batch.push_back(make_result(KIND_HEAD, 16'd0, timer_list[0].deadline));
                else
                    batch.push_back(make_result(KIND_HEAD, 16'd0, '0));
            end
            default: begin
                // Undecoded command: no result and no change.
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_results.push_back(batch[i]);
    endtask

    task automatic queue_request(input logic [1:0] cmd, input logic [31:0] now_sec,
                                 input logic [19:0] now_usec, input logic [31:0] delay_sec,
                                 input logic [19:0] delay_usec, input logic [15:0] tag,
                                 input logic drain_first);
        t_request r;
        r.cmd         = cmd;
        r.now_sec     = now_sec;
        r.now_usec    = now_usec;
        r.delay_sec   = delay_sec;
        r.delay_usec  = delay_usec;
        r.tag         = tag;
        r.drain_first = drain_first;
        pending_requests.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Driver. Inputs change on the falling edge. The throttle works in three
    // phases over the request count: a fast sender against a slow receiver
    // (35/73 percent idle), then the rates swapped, then both at full rate.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (sent_count * 3 < total_requests) begin
            tx_idle_pct = 35;
            rx_idle_pct = 73;
        end else if (sent_count * 3 < total_requests * 2) begin
            tx_idle_pct = 73;
            rx_idle_pct = 35;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            // A new request is only presented once the current one is taken.
            if (!i_s_tvalid || request_taken) begin
                if (pending_requests.size() > 0
                        && (!pending_requests[0].drain_first || expected_results.size() == 0)
                        && $urandom_range(99) >= tx_idle_pct) begin
                    next_request = pending_requests.pop_front();
                    sent_count++;
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= next_request.cmd;
                    i_s_tdata  <= {next_request.tag, next_request.delay_usec,
                                   next_request.delay_sec, next_request.now_usec,
                                   next_request.now_sec};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Both streams are sampled on the rising edge. Accepted requests
    // feed the timer list; accepted results are compared with the oldest
    // expectation. The watchdog counts edges with no transfer on either side.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        request_taken <= i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                predict_timer_results(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result kind %0d tag %h sec %h usec %h last %b",
                                 $time, o_m_tuser, o_m_tdata[15:0], o_m_tdata[47:16],
                                 o_m_tdata[67:48], o_m_tlast);
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (o_m_tuser !== oldest_result.kind
                            || o_m_tdata[15:0] !== oldest_result.tag
                            || o_m_tdata[47:16] !== oldest_result.sec
                            || o_m_tdata[67:48] !== oldest_result.usec
                            || o_m_tlast !== oldest_result.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"%0t: result mismatch: kind %0d/%0d tag %h/%h ",
                                      "sec %h/%h usec %h/%h last %b/%b (expected/actual)"},
                                     $time, oldest_result.kind, o_m_tuser,
                                     oldest_result.tag, o_m_tdata[15:0],
                                     oldest_result.sec, o_m_tdata[47:16],
                                     oldest_result.usec, o_m_tdata[67:48],
                                     oldest_result.last, o_m_tlast);
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned random_count;
        int unsigned burst_len;
        int unsigned pick;
        int unsigned step_usec;
        logic        fill_burst;
        logic [1:0]  cmd;
        logic [31:0] clock_sec;
        int unsigned clock_usec;
        logic [31:0] ns;
        logic [19:0] nu;
        logic [31:0] ds;
        logic [19:0] du;
        logic [31:0] prev_ns;
        logic [19:0] prev_nu;
        logic [31:0] prev_ds;
        logic [19:0] prev_du;

        // Directed opening. The empty queue answers a query and a check.
        queue_request(CMD_QUERY, 32'd1000, 20'd500000, 32'd0, 20'd0, 16'h0000, 1'b0);
        queue_request(CMD_CHECK, 32'd1000, 20'd500000, 32'd0, 20'd0, 16'h0000, 1'b0);
        // Zero delay fires at once.
        queue_request(CMD_INSERT, 32'd1000, 20'd500000, 32'd0, 20'd0, 16'h0001, 1'b0);
        // Microsecond carry of the sum; the first entry raises an alarm.
        queue_request(CMD_INSERT, 32'd1000, 20'd999999, 32'd2, 20'd999999, 16'h0002, 1'b0);
        // Microsecond fields beyond one second in both now and delay; the
        // earlier deadline takes over the head.
        queue_request(CMD_INSERT, 32'd1000, 20'hFFFFF, 32'd0, 20'hFFFFF, 16'h0003, 1'b0);
        // Same deadline as an existing entry: it queues behind, silently.
        queue_request(CMD_INSERT, 32'd1000, 20'd999999, 32'd2, 20'd999999, 16'h0004, 1'b0);
        // Now at the largest time: the saturated deadline is already due.
        queue_request(CMD_INSERT, 32'hFFFF_FFFF, 20'd999999, 32'd0, 20'd5, 16'hFFFF, 1'b0);
        // Saturated delay gives the largest deadline, stored at the tail.
        queue_request(CMD_INSERT, 32'd1000, 20'd0, 32'hFFFF_FFFF, 20'hFFFFF, 16'h00AA, 1'b0);
        queue_request(CMD_UNUSED, 32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF, 20'hFFFFF,
                      16'hFFFF, 1'b0);
        queue_request(CMD_QUERY, 32'd1000, 20'd0, 32'd0, 20'd0, 16'h0000, 1'b0);
        // Fill the queue to its depth; a zero delay then still fires at once on the full queue.
        for (int i = 0; i < 12; i++)
            queue_request(CMD_INSERT, 32'd1004, 20'd0, 32'(10 + i), 20'(i * 1000),
                          16'(16'h1000 + i), 1'b0);
        queue_request(CMD_INSERT, 32'd1004, 20'd0, 32'd5, 20'd0, 16'h2000, 1'b0);
        queue_request(CMD_INSERT, 32'd1004, 20'd0, 32'd0, 20'd0, 16'h2001, 1'b0);
        // Partial expiry including the equal deadlines, then a closing alarm.
        queue_request(CMD_CHECK, 32'd1003, 20'd999998, 32'd0, 20'd0, 16'h0000, 1'b0);
        // Flush everything once the block has gone quiet.
        queue_request(CMD_CHECK, 32'hFFFF_FFFF, 20'd999999, 32'd0, 20'd0, 16'h0000, 1'b1);
        queue_request(CMD_QUERY, 32'd0, 20'd0, 32'd0, 20'd0, 16'h0000, 1'b0);

        // Random traffic in bursts. Most bursts follow a running clock with
        // short delays, so entries expire under later checks; some bursts
        // load long timeouts to push the queue to full.
        clock_sec    = 32'd5000;
        clock_usec   = 0;
        prev_ns      = clock_sec;
        prev_nu      = 20'd0;
        prev_ds      = 32'd1;
        prev_du      = 20'd0;
        random_count = 0;
        while (random_count < RANDOM_REQUESTS) begin
            fill_burst = ($urandom_range(9) == 0);
            burst_len  = $urandom_range(4, 16);
            for (int j = 0; j < burst_len && random_count < RANDOM_REQUESTS; j++) begin
                step_usec  = $urandom_range(0, 900000);
                clock_usec = clock_usec + step_usec;
                clock_sec  = clock_sec + 32'($urandom_range(0, 1));
                if (clock_usec >= 1000000) begin
                    clock_usec = clock_usec - 1000000;
                    clock_sec  = clock_sec + 32'd1;
                end

                pick = $urandom_range(99);
                if (fill_burst)
                    cmd = (pick < 85) ? CMD_INSERT : (pick < 95) ? CMD_CHECK : CMD_QUERY;
                else
                    cmd = (pick < 50) ? CMD_INSERT : (pick < 78) ? CMD_CHECK :
                          (pick < 95) ? CMD_QUERY : CMD_UNUSED;

                pick = $urandom_range(99);
                if (pick < 90) begin
                    ns = clock_sec;
                    nu = 20'(clock_usec);
                end else if (pick < 96) begin
                    ns = $urandom();
                    nu = 20'($urandom_range(0, 20'hFFFFF));
                end else begin
                    ns = 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
                    nu = 20'($urandom_range(0, 999999));
                end
                // Fields the command does not use still carry noise.
                ds = $urandom();
                du = 20'($urandom_range(0, 20'hFFFFF));

                if (cmd == CMD_CHECK && $urandom_range(24) == 0) begin
                    ns = SEC_MAX;
                    nu = USEC_MAX;
                end else if (cmd == CMD_INSERT) begin
                    pick = $urandom_range(99);
                    if (fill_burst) begin
                        ds = 32'($urandom_range(100, 100000));
                        du = 20'($urandom_range(0, 999999));
                    end else if (pick < 8) begin
                        ds = 32'd0;
                        du = 20'd0;
                    end else if (pick < 14) begin
                        ds = 32'd0;
                        du = 20'($urandom_range(1, 999999));
                    end else if (pick < 66) begin
                        ds = 32'($urandom_range(0, 3));
                        du = 20'($urandom_range(0, 999999));
                    end else if (pick < 78) begin
                        // Same now and delay as the previous insert: a tie.
                        ns = prev_ns;
                        nu = prev_nu;
                        ds = prev_ds;
                        du = prev_du;
                    end else if (pick < 88) begin
                        ds = 32'($urandom_range(100, 100000));
                        du = 20'($urandom_range(0, 999999));
                    end else if (pick < 94) begin
                        ds = $urandom();
                        du = 20'($urandom_range(0, 999999));
                    end else begin
                        ds = 32'($urandom_range(0, 2));
                        du = 20'($urandom_range(1000000, 20'hFFFFF));
                    end
                    prev_ns = ns;
                    prev_nu = nu;
                    prev_ds = ds;
                    prev_du = du;
                end

                if (cmd != CMD_UNUSED)
                    random_count++;
                queue_request(cmd, ns, nu, ds, du, 16'($urandom()),
                              (random_count % 60 == 59));
            end
        end
        total_requests = pending_requests.size();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every request accepted, then every result received, then a quiet
        // stretch to catch stray results.
        while (pending_requests.size() > 0 || i_s_tvalid)
            @(posedge i_clk);
        while (expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
